FILE: hdl/rod_cutting_max_revenue_assert.svh
// assertion macros shared by the rod cutting block
`ifndef ROD_CUTTING_MAX_REVENUE_ASSERT_SVH
`define ROD_CUTTING_MAX_REVENUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RCMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rod cutting assertion failed");

// next-cycle implication, checked outside reset
`define RCMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rod cutting assertion failed");

`endif

FILE: hdl/rcmr_pkg.sv
// shared types and constants for the rod cutting block
`default_nettype none

package rcmr_pkg;

    // default sizing
    localparam int DEF_MAX_LENGTH = 64;
    localparam int DEF_PRICE_BITS = 16;

    // fixed field widths
    localparam int PRICE_W = 16;
    localparam int LEN_W   = 7;
    localparam int BEST_W  = 22;

    // largest best revenue, sums above it saturate
    localparam logic [BEST_W-1:0] BEST_MAX = {BEST_W{1'b1}};

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // control of the shared add and compare unit
    typedef struct packed {
        logic clear;
        logic en;
        logic use_best;
    } t_acc_ctl;

endpackage

`default_nettype wire

FILE: hdl/rcmr_if.sv
// valid/ready channels for prices in and best revenues out
`default_nettype none

interface rcmr_in_if import rcmr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] piece_price;
    logic               restart;

    modport source (output valid, piece_price, restart, input ready);
    modport sink   (input valid, piece_price, restart, output ready);
endinterface

interface rcmr_out_if import rcmr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  rod_length;
    logic [BEST_W-1:0] best_revenue;
    logic              overflow;

    modport source (output valid, rod_length, best_revenue, overflow, input ready);
    modport sink   (input valid, rod_length, best_revenue, overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/rcmr_ram.sv
// single write port, single registered read port memory
`default_nettype none

module rcmr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hdl/rcmr_maxacc.sv
// shared add and compare unit: running maximum of price plus best revenue
`default_nettype none

module rcmr_maxacc import rcmr_pkg::*; #(
    parameter int PRICE_BITS = DEF_PRICE_BITS
) (
    input  wire logic                  i_clk,
    input  wire t_acc_ctl              i_ctl,
    input  wire logic [PRICE_BITS-1:0] i_price,
    input  wire logic [BEST_W-1:0]     i_best,
    output logic      [BEST_W-1:0]     o_top
);

    localparam int SW = ((PRICE_BITS > BEST_W) ? PRICE_BITS : BEST_W) + 1;

    logic [SW-1:0] r_top;
    logic [SW-1:0] n_top;
    logic [SW-1:0] sum;

    // one candidate sum per cycle
    always_comb begin
        sum = SW'(i_price) + (i_ctl.use_best ? SW'(i_best) : SW'(0));
        n_top = r_top;
        if (i_ctl.clear) begin
            n_top = '0;
        end else if (i_ctl.en && (sum > r_top)) begin
            n_top = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    // saturate to the result width
    assign o_top = (r_top > SW'(BEST_MAX)) ? BEST_MAX : r_top[BEST_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/rod_cutting_max_revenue.sv
// rod cutting revenue block: sequencer, price and best stores, output register
//
// Input channel i_in carries the price of the next rod length, starting at
// length one; restart set begins a new price list with this item as length
// one. Output channel o_out returns exactly one item per input: the rod
// length, the best revenue for that length, and an overflow flag.
// For new length i the block scans j = 1..i, one add and compare per cycle in
// a shared unit, reading price(j) and best(i-j) from two memories with one
// registered read port each. A stored item passes a scan state, a drain
// state for the last sum and a finish state, which loads the output register
// once it is free; the next item is taken only after that load.
// An item arriving with the store full and no restart is not stored and
// reports length 0, revenue 0, overflow 1. The input is not
// ready while an item is being worked on. The output register holds a result
// until it is taken; a stalled receiver only delays the hand-off of the next
// result, and the block can already accept and scan the following item.
// Reset clears the length count, the sequencer and the output valid; store
// contents stay as they are and are always rewritten before being read.
`default_nettype none

module rod_cutting_max_revenue import rcmr_pkg::*; #(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH,
    parameter int PRICE_BITS = DEF_PRICE_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcmr_in_if.sink    i_in,
    rcmr_out_if.source o_out
);

    `include "rod_cutting_max_revenue_assert.svh"

    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

    t_state r_state;
    t_state n_state;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_j;
    logic          r_ovf;
    logic          r_pend;
    logic          r_use_best;

    logic              r_out_valid;
    logic [LEN_W-1:0]  r_out_len;
    logic [BEST_W-1:0] r_out_best;
    logic              r_out_ovf;

    logic in_xfer;
    logic in_ovf;
    logic out_free;
    logic issue;
    logic last_issue;
    logic load_out;
    logic best_we;

    logic [CW-1:0]         new_count;
    logic [CW-1:0]         price_wr_addr;
    logic [CW-1:0]         best_rd_addr;
    logic [CW-1:0]         best_wr_addr;
    logic [CW-1:0]         price_rd_addr;
    logic [PRICE_BITS-1:0] price_in;
    logic [PRICE_BITS-1:0] price_rd;
    logic [BEST_W-1:0]     best_rd;
    logic [BEST_W-1:0]     top;
    logic [CW+LEN_W-1:0]   len_ext;
    logic [PRICE_W+PRICE_BITS-1:0] price_ext;
    t_acc_ctl              acc_ctl;

    // input transfer decode
    assign in_xfer  = i_in.valid && i_in.ready;
    assign in_ovf   = !i_in.restart && (r_count == CW'(MAX_LENGTH));
    assign out_free = !r_out_valid || o_out.ready;
    assign last_issue = (r_j == r_len);

    always_comb begin
        new_count = i_in.restart ? CW'(1) : (r_count + CW'(1));
        price_wr_addr = i_in.restart ? CW'(0) : r_count;
        price_ext = {PRICE_BITS'(0), i_in.piece_price};
        price_in = price_ext[PRICE_BITS-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = in_ovf ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            S_IDLE:   i_in.ready = 1'b1;
            S_SCAN:   issue      = 1'b1;
            S_DRAIN:  issue      = 1'b0;
            S_FINISH: load_out   = out_free;
            default:  issue      = 1'b0;
        endcase
    end

    assign best_we = load_out && !r_ovf;

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            if (in_xfer && !in_ovf) begin
                r_count <= new_count;
            end
        end
    end

    // scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_use_best <= (r_len != r_j);
        if (in_xfer) begin
            r_len <= new_count;
            r_j   <= CW'(1);
            r_ovf <= in_ovf;
        end else if (issue) begin
            r_j <= r_j + CW'(1);
        end
    end

    // store addressing
    always_comb begin
        price_rd_addr = r_j - CW'(1);
        best_rd_addr  = r_len - r_j - CW'(1);
        best_wr_addr  = r_len - CW'(1);
    end

    rcmr_ram #(
        .WIDTH (PRICE_BITS),
        .DEPTH (MAX_LENGTH),
        .AW    (AW)
    ) u_price_ram (
        .i_clk     (i_clk),
        .i_we      (in_xfer && !in_ovf),
        .i_wr_addr (price_wr_addr[AW-1:0]),
        .i_wr_data (price_in),
        .i_rd_addr (price_rd_addr[AW-1:0]),
        .o_rd_data (price_rd)
    );

    rcmr_ram #(
        .WIDTH (BEST_W),
        .DEPTH (MAX_LENGTH),
        .AW    (AW)
    ) u_best_ram (
        .i_clk     (i_clk),
        .i_we      (best_we),
        .i_wr_addr (best_wr_addr[AW-1:0]),
        .i_wr_data (top),
        .i_rd_addr (best_rd_addr[AW-1:0]),
        .o_rd_data (best_rd)
    );

    // shared add and compare unit, enabled in the cycle after the read issue
    always_comb begin
        acc_ctl.clear    = in_xfer;
        acc_ctl.en       = r_pend;
        acc_ctl.use_best = r_use_best;
    end

    rcmr_maxacc #(
        .PRICE_BITS (PRICE_BITS)
    ) u_maxacc (
        .i_clk   (i_clk),
        .i_ctl   (acc_ctl),
        .i_price (price_rd),
        .i_best  (best_rd),
        .o_top   (top)
    );

    // output register
    assign len_ext = {LEN_W'(0), r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_len  <= r_ovf ? LEN_W'(0) : len_ext[LEN_W-1:0];
            r_out_best <= r_ovf ? BEST_W'(0) : top;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.rod_length   = r_out_len;
    assign o_out.best_revenue = r_out_best;
    assign o_out.overflow     = r_out_ovf;

    // checks on the sequencer
    `RCMR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_LENGTH))
    `RCMR_ASSERT_NOW(a_scan_range, i_clk, i_rst_n, r_state == S_SCAN,
        (r_j != CW'(0)) && (r_j <= r_len))
    `RCMR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_xfer, r_state != S_IDLE)
    `RCMR_ASSERT_NEXT(a_load_from_finish, i_clk, i_rst_n, !r_out_valid,
        !r_out_valid || ($past(r_state) == S_FINISH))

endmodule

`default_nettype wire
